// File: hdl/srav_pkg.sv
package srav_pkg;

   localparam int CHANNELS   = 4;
   localparam int RING_DEPTH = 16384;
   localparam int MAX_PULL   = 64;

   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IDX_W     = $clog2(RING_DEPTH);
   localparam int MEM_DEPTH = CHANNELS * RING_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int FW        = (IDX_W > 7) ? IDX_W : 7;
   localparam int DVD_W     = FW + 32;
   localparam int DVS_W     = 18;

   // 0.1 s and 0.002 s in Q32.32
   localparam logic [63:0] RESYNC_T = 64'd429496730;
   localparam logic [63:0] PULL_T   = 64'd8589935;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_PULL  = 2'd1;
   localparam logic [1:0] OP_RESET = 2'd2;

   localparam logic CSR_RATE    = 1'b0;
   localparam logic CSR_PLAYING = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV_ADV,
      ST_DIV_LAG,
      ST_CALC_A,
      ST_CALC_B,
      ST_DECIDE,
      ST_NUDGE,
      ST_FRAME_RD,
      ST_FRAME_OUT,
      ST_STATUS
   } ctrl_state_type;

   typedef struct packed {
      logic latch;
      logic do_write;
      logic do_reset;
      logic frames_init;
      logic pull_commit;
      logic div_start_adv;
      logic div_start_lag;
      logic save_adv;
      logic save_lag;
      logic calc_a;
      logic calc_b;
      logic decide;
      logic apply_ten;
      logic rd_issue;
      logic emit_frame;
      logic emit_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       invalid;
      logic       playing;
      logic       fc_zero;
      logic       div_done;
      logic       need_ten;
      logic       frame_final;
      logic       out_free;
   } ctrl_status_type;

endpackage

// File: hdl/srav_div.sv
module srav_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [srav_pkg::DVD_W-1:0] dividend,
   input  logic [srav_pkg::DVS_W-1:0] divisor,
   output logic [srav_pkg::DVD_W-1:0] quotient,
   output logic                       done
);
   import srav_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DVS_W:0]   trial;
   logic             ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      ge     = trial >= {1'b0, dvs_ff};
      rem_in = ge ? DVS_W'(trial - {1'b0, dvs_ff}) : DVS_W'(trial);
      quo_in = {quo_ff[DVD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// File: hdl/srav_ctrl.sv
module srav_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  srav_pkg::ctrl_status_type status,
   output srav_pkg::ctrl_cmd_type    cmd
);
   import srav_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.invalid) begin
               state_in = ST_STATUS;
            end else if (status.op == OP_WRITE) begin
               cmd.do_write = 1'b1;
               state_in     = ST_STATUS;
            end else if (status.op == OP_RESET) begin
               cmd.do_reset = 1'b1;
               state_in     = ST_STATUS;
            end else begin
               cmd.frames_init = 1'b1;
               if (status.playing) begin
                  cmd.pull_commit = 1'b1;
                  if (status.fc_zero) begin
                     state_in = ST_STATUS;
                  end else begin
                     cmd.div_start_adv = 1'b1;
                     state_in          = ST_DIV_ADV;
                  end
               end else if (status.fc_zero) begin
                  state_in = ST_STATUS;
               end else begin
                  state_in = ST_FRAME_RD;
               end
            end
         end
         ST_DIV_ADV: begin
            if (status.div_done) begin
               cmd.save_adv      = 1'b1;
               cmd.div_start_lag = 1'b1;
               state_in          = ST_DIV_LAG;
            end
         end
         ST_DIV_LAG: begin
            if (status.div_done) begin
               cmd.save_lag = 1'b1;
               state_in     = ST_CALC_A;
            end
         end
         ST_CALC_A: begin
            cmd.calc_a = 1'b1;
            state_in   = ST_CALC_B;
         end
         ST_CALC_B: begin
            cmd.calc_b = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.need_ten) begin
               state_in = ST_NUDGE;
            end else begin
               state_in = ST_FRAME_RD;
            end
         end
         ST_NUDGE: begin
            cmd.apply_ten = 1'b1;
            state_in      = ST_FRAME_RD;
         end
         ST_FRAME_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_FRAME_OUT;
         end
         ST_FRAME_OUT: begin
            if (status.out_free) begin
               cmd.emit_frame = 1'b1;
               state_in       = status.frame_final ? ST_IDLE : ST_FRAME_RD;
            end
         end
         ST_STATUS: begin
            if (status.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/srav_dp.sv
module srav_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  srav_pkg::ctrl_cmd_type    cmd,
   output srav_pkg::ctrl_status_type status,
   input  logic [1:0]                in_op,
   input  logic [1:0]                in_channel,
   input  logic [23:0]               in_left,
   input  logic [23:0]               in_right,
   input  logic                      in_frame_last,
   input  logic [63:0]               in_timestamp,
   input  logic [6:0]                in_frame_count,
   input  logic [17:0]               rate_cfg,
   input  logic                      playing,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [23:0]               rsp_left,
   output logic [23:0]               rsp_right,
   output logic                      rsp_last,
   output logic                      rsp_accepted,
   output logic [6:0]                rsp_delivered,
   output logic [13:0]               rsp_buffered,
   output logic [63:0]               rsp_read_head,
   output logic                      rsp_master_active
);
   import srav_pkg::*;

   function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W:0] a,
                                                input logic [IDX_W:0] b);
      logic [IDX_W+1:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (IDX_W+2)'(RING_DEPTH)) s = s - (IDX_W+2)'(RING_DEPTH);
      return IDX_W'(s);
   endfunction

   // latched item
   logic [1:0]  op_ff;
   logic [1:0]  ch_ff;
   logic [23:0] left_ff, right_ff;
   logic        fl_ff;
   logic [63:0] ts_ff;
   logic [6:0]  fc_ff;

   // per-channel state
   logic [IDX_W-1:0] widx_ff  [CHANNELS];
   logic [IDX_W-1:0] ridx_ff  [CHANNELS];
   logic [63:0]      rclk_ff  [CHANNELS];
   logic [63:0]      wclk_ff  [CHANNELS];
   logic             drained_ff [CHANNELS];

   // pull work registers
   logic [63:0]      adv_ff, lag_ff, nt_ff, exp_ff, err_ff;
   logic [28:0]      ten_ff;
   logic [6:0]       n_ff, i_ff;
   logic [IDX_W-1:0] rp_ff;
   logic             acc_ff;
   logic [47:0]      rd_data_ff;
   logic [47:0]      mem [MEM_DEPTH];

   // output register
   logic        rsp_valid_ff;
   logic [23:0] rsp_left_ff, rsp_right_ff;
   logic        rsp_last_ff, rsp_acc_ff, rsp_master_ff;
   logic [6:0]  rsp_deliv_ff;
   logic [13:0] rsp_buf_ff;
   logic [63:0] rsp_head_ff;

   logic [CH_W-1:0]  c;
   logic [IDX_W-1:0] fill, rd_idx;
   logic             room, invalid, st_valid, out_free, frame_final, load;
   logic [6:0]       n_comb;
   logic [63:0]      mag, ten_prod;
   logic             over_resync, over_pull;
   logic [ADDR_W-1:0] waddr, raddr;
   logic             div_start, div_done;
   logic [DVD_W-1:0] dividend, quotient;
   logic [DVS_W-1:0] sr_eff;

   assign c       = ch_ff[CH_W-1:0];
   assign invalid = (op_ff == 2'd3) || (int'(ch_ff) >= CHANNELS);
   assign st_valid = !invalid;

   always_comb begin
      if (widx_ff[c] >= ridx_ff[c]) begin
         fill = widx_ff[c] - ridx_ff[c];
      end else begin
         fill = IDX_W'({1'b0, widx_ff[c]} + (IDX_W+1)'(RING_DEPTH) - {1'b0, ridx_ff[c]});
      end
      room   = fill != IDX_W'(RING_DEPTH - 1);
      n_comb = (FW'(fc_ff) < FW'(fill)) ? fc_ff : 7'(fill);
      rd_idx = add_mod({1'b0, rp_ff}, (IDX_W+1)'(i_ff));
      waddr  = ADDR_W'(c) * ADDR_W'(RING_DEPTH) + ADDR_W'(widx_ff[c]);
      raddr  = ADDR_W'(c) * ADDR_W'(RING_DEPTH) + ADDR_W'(rd_idx);
      mag    = err_ff[63] ? (64'd0 - err_ff) : err_ff;
      over_resync = mag > RESYNC_T;
      over_pull   = mag > PULL_T;
      // mag / 10 by reciprocal; only used when mag is below the resync threshold
      ten_prod = 64'(mag[31:0]) * 64'(32'hCCCC_CCCD);
   end

   assign sr_eff    = (rate_cfg == '0) ? DVS_W'(1) : rate_cfg;
   assign div_start = cmd.div_start_adv | cmd.div_start_lag;

   always_comb begin
      dividend = DVD_W'({fc_ff, 32'd0});
      if (cmd.div_start_lag) begin
         dividend = DVD_W'({fill, 32'd0});
      end
   end

   srav_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (sr_eff),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CHANNELS; k++) begin
            widx_ff[k]    <= '0;
            ridx_ff[k]    <= '0;
            rclk_ff[k]    <= '0;
            wclk_ff[k]    <= '0;
            drained_ff[k] <= 1'b0;
         end
      end else begin
         if (cmd.do_write) begin
            if (room) widx_ff[c] <= add_mod({1'b0, widx_ff[c]}, (IDX_W+1)'(1));
            if (fl_ff) wclk_ff[c] <= ts_ff;
         end
         if (cmd.do_reset) begin
            widx_ff[c]    <= '0;
            ridx_ff[c]    <= '0;
            rclk_ff[c]    <= ts_ff;
            wclk_ff[c]    <= ts_ff;
            drained_ff[c] <= 1'b0;
         end
         if (cmd.pull_commit) begin
            ridx_ff[c]    <= add_mod({1'b0, ridx_ff[c]}, (IDX_W+1)'(n_comb));
            drained_ff[c] <= 1'b1;
         end
         if (cmd.decide) begin
            if (over_resync) begin
               rclk_ff[c] <= exp_ff + adv_ff;
            end else if (!over_pull) begin
               rclk_ff[c] <= nt_ff;
            end
         end
         if (cmd.apply_ten) begin
            rclk_ff[c] <= err_ff[63] ? nt_ff + 64'(ten_ff) : nt_ff - 64'(ten_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= in_op;
         ch_ff    <= in_channel;
         left_ff  <= in_left;
         right_ff <= in_right;
         fl_ff    <= in_frame_last;
         ts_ff    <= in_timestamp;
         fc_ff    <= (in_frame_count > 7'(MAX_PULL)) ? 7'(MAX_PULL) : in_frame_count;
         acc_ff   <= 1'b0;
      end
      if (cmd.do_write) acc_ff <= room;
      if (cmd.frames_init) begin
         i_ff  <= '0;
         n_ff  <= playing ? n_comb : 7'd0;
         rp_ff <= ridx_ff[c];
      end
      if (cmd.emit_frame) i_ff <= i_ff + 7'd1;
      if (cmd.save_adv) adv_ff <= 64'(quotient);
      if (cmd.save_lag) lag_ff <= 64'(quotient);
      if (cmd.calc_a) begin
         nt_ff  <= rclk_ff[c] + adv_ff;
         exp_ff <= wclk_ff[c] - lag_ff;
      end
      if (cmd.calc_b) err_ff <= nt_ff - exp_ff;
      if (cmd.decide) ten_ff <= ten_prod[63:35];
   end

   always_ff @(posedge clock) begin
      if (cmd.do_write && room) mem[waddr] <= {right_ff, left_ff};
      if (cmd.rd_issue) rd_data_ff <= mem[raddr];
   end

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign frame_final = (i_ff + 7'd1) == fc_ff;
   assign load        = cmd.emit_frame | cmd.emit_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_acc_ff    <= cmd.emit_status & acc_ff;
         rsp_buf_ff    <= st_valid ? 14'(fill) : 14'd0;
         rsp_head_ff   <= st_valid ? rclk_ff[c] : 64'd0;
         rsp_master_ff <= st_valid & drained_ff[c];
         if (cmd.emit_frame) begin
            rsp_left_ff  <= (i_ff < n_ff) ? rd_data_ff[23:0] : 24'd0;
            rsp_right_ff <= (i_ff < n_ff) ? rd_data_ff[47:24] : 24'd0;
            rsp_last_ff  <= frame_final;
            rsp_deliv_ff <= n_ff;
         end else begin
            rsp_left_ff  <= 24'd0;
            rsp_right_ff <= 24'd0;
            rsp_last_ff  <= 1'b1;
            rsp_deliv_ff <= 7'd0;
         end
      end
   end

   always_comb begin
      status.op          = op_ff;
      status.invalid     = invalid;
      status.playing     = playing;
      status.fc_zero     = fc_ff == 7'd0;
      status.div_done    = div_done;
      status.need_ten    = !over_resync && over_pull;
      status.frame_final = frame_final;
      status.out_free    = out_free;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left          = rsp_left_ff;
   assign rsp_right         = rsp_right_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_delivered     = rsp_deliv_ff;
   assign rsp_buffered      = rsp_buf_ff;
   assign rsp_read_head     = rsp_head_ff;
   assign rsp_master_active = rsp_master_ff;

   a_final_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_frame && frame_final |=> rsp_valid_ff && rsp_last_ff)
      else $error("final frame word not marked last");

   a_delivered_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.frames_init |=> n_ff <= fc_ff)
      else $error("delivered count exceeds request");

   a_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.pull_commit |=> drained_ff[c])
      else $error("drained flag not set after playing pull");

endmodule

// File: hdl/stereo_ring_with_av_clock.sv
// Four stereo rings of Q1.23 frames, 16383 frames each, with a Q32.32 playback
// clock per channel. Items are handled one at a time; req_tready is high only
// while the block is idle. A write, channel reset, unknown op or pull of zero
// frames goes from decode straight to the status state, which loads its status
// word when the output register is free; the next word is accepted once idle.
// A paused pull reads each frame word on the single ring read port and then loads
// it into the output register. A playing pull runs the shared radix-2 divider
// twice (advance and lag, 46 quotient bits each), then the clock math states
// CALC_A, CALC_B and DECIDE, and a NUDGE state when the clock is nudged by a
// tenth of its error, before its frame words. Stalls on rsp_tready hold output.
module stereo_ring_with_av_clock (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // left_sample[23:0], right_sample[47:24], timestamp[111:48],
   // frame_count[118:112], zero pad
   input  logic [119:0] req_tdata,
   // op[1:0], channel[3:2]
   input  logic [3:0]   req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // left_out[23:0], right_out[47:24], accepted[48], delivered[55:49],
   // buffered[69:56], read_head[133:70], master_active[134], zero pad
   output logic [135:0] rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [17:0]  csr_data
);
   import srav_pkg::*;

   logic [17:0] rate_cfg_ff;
   logic        playing_ff;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   logic [23:0] left_out, right_out;
   logic        accepted, master_active;
   logic [6:0]  delivered;
   logic [13:0] buffered;
   logic [63:0] read_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_cfg_ff <= 18'd48000;
         playing_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE:    rate_cfg_ff <= csr_data;
            CSR_PLAYING: playing_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   srav_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   srav_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .in_op             (req_tuser[1:0]),
      .in_channel        (req_tuser[3:2]),
      .in_left           (req_tdata[23:0]),
      .in_right          (req_tdata[47:24]),
      .in_frame_last     (req_tlast),
      .in_timestamp      (req_tdata[111:48]),
      .in_frame_count    (req_tdata[118:112]),
      .rate_cfg          (rate_cfg_ff),
      .playing           (playing_ff),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_left          (left_out),
      .rsp_right         (right_out),
      .rsp_last          (rsp_tlast),
      .rsp_accepted      (accepted),
      .rsp_delivered     (delivered),
      .rsp_buffered      (buffered),
      .rsp_read_head     (read_head),
      .rsp_master_active (master_active)
   );

   assign rsp_tdata = {1'b0, master_active, read_head, buffered, delivered, accepted,
                       right_out, left_out};

endmodule
